@@ sv/waypoint_axis_sequencer_macros.svh @@
// Assertion macros shared by the waypoint axis sequencer checkers.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef WAYPOINT_AXIS_SEQUENCER_MACROS_SVH
`define WAYPOINT_AXIS_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/wps_pkg.sv @@
// Shared types, constants and tables for the waypoint axis sequencer.
// No dependencies; every module of the block imports this package.
package wps_pkg;

  // Stage numbering and the stages at which the outputs change behavior.
  localparam int unsigned STAGE_W = 4;
  localparam logic [STAGE_W-1:0] NUM_STAGES      = 4'd13;
  localparam logic [STAGE_W-1:0] SPLIT_STAGE     = 4'd4;
  localparam logic [STAGE_W-1:0] FLAT_STAGE      = 4'd3;
  localparam logic [STAGE_W-1:0] BELT_FIRST      = 4'd4;
  localparam logic [STAGE_W-1:0] BELT_LAST       = 4'd8;
  localparam logic [STAGE_W-1:0] HALF_STAGE_LU   = 4'd6;
  localparam logic [STAGE_W-1:0] HALF_STAGE_FORE = 4'd3;

  // Field widths.
  localparam int unsigned GOAL_W  = 21;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned DRIVE_W = 16;

  // Drive arithmetic: q = floor((x * K + 25) / 50), done as a multiply by a
  // rounded-up reciprocal of 50 followed by a right shift.
  localparam int unsigned X_W       = 13;
  localparam int unsigned Q_W       = 15;
  localparam int unsigned RECIP_W   = 22;
  localparam int unsigned COEF_W    = 35;
  localparam int unsigned PROD_W    = 48;
  localparam int unsigned DIV_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP50   = 22'd2684355;
  localparam logic [COEF_W-1:0]  ROUND_OFS = 35'd67108875;
  localparam logic [Q_W-1:0]     DRIVE_FULL = 15'd25600;
  localparam logic [Q_W-1:0]     DRIVE_HALF = 15'd12800;

  // Gains per count, scaled so that every axis divides by 50.
  localparam logic [X_W-1:0] K_LIN_FULL  = 13'd384;
  localparam logic [X_W-1:0] K_LIN_HALF  = 13'd192;
  localparam logic [X_W-1:0] K_UP_FULL   = 13'd7680;
  localparam logic [X_W-1:0] K_UP_HALF   = 13'd3840;
  localparam logic [X_W-1:0] K_FORE_FULL = 13'd192;
  localparam logic [X_W-1:0] K_FORE_HALF = 13'd96;
  localparam logic [X_W-1:0] K_TILT      = 13'd192;

  // Smallest error magnitude that drives an axis into the 100 percent clip.
  localparam logic [X_W-1:0] THR_LIN  = 13'd3334;
  localparam logic [X_W-1:0] THR_UP   = 13'd167;
  localparam logic [X_W-1:0] THR_FORE = 13'd6667;
  localparam logic [X_W-1:0] THR_TILT = 13'd6667;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_LINEAR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_UPPER_ARM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_FOREARM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_TILT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_A       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_B       = 3'd5;
  localparam logic [TOL_W-1:0]   RST_TOL_LINEAR    = 16'd1000;
  localparam logic [TOL_W-1:0]   RST_TOL_UPPER_ARM = 16'd100;
  localparam logic [TOL_W-1:0]   RST_TOL_FOREARM   = 16'd2000;
  localparam logic [TOL_W-1:0]   RST_TOL_TILT      = 16'd1000;
  localparam logic [STAGE_W-1:0] RST_START_A       = 4'd1;
  localparam logic [STAGE_W-1:0] RST_START_B       = 4'd4;

  // Result bus layout, lowest bit first.
  localparam int unsigned OUT_W           = 72;
  localparam int unsigned OUT_OBLIQUE_BIT = 64;
  localparam int unsigned OUT_FLAT_BIT    = 65;
  localparam int unsigned OUT_BELT_BIT    = 66;
  localparam int unsigned OUT_STAGE_LSB   = 67;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_A   = 2'd1,
    MODE_B   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    AX_LINEAR    = 2'd0,
    AX_UPPER_ARM = 2'd1,
    AX_FOREARM   = 2'd2,
    AX_TILT      = 2'd3
  } axis_e;

  typedef struct packed {
    logic run_b;
    logic run_a;
    logic confirm;
    logic enable;
  } btn_t;

  typedef struct packed {
    mode_e              mode;
    logic [STAGE_W-1:0] stage;
    logic               latch;
  } state_t;

  typedef struct packed {
    logic [TOL_W-1:0]   tol_tilt;
    logic [TOL_W-1:0]   tol_forearm;
    logic [TOL_W-1:0]   tol_upper_arm;
    logic [TOL_W-1:0]   tol_linear;
    logic [STAGE_W-1:0] start_b;
    logic [STAGE_W-1:0] start_a;
  } cfg_t;

  typedef struct packed {
    logic [STAGE_W-1:0]        stage;
    logic                      belt;
    logic                      flat;
    logic                      oblique;
    logic signed [DRIVE_W-1:0] tilt;
    logic signed [DRIVE_W-1:0] forearm;
    logic signed [DRIVE_W-1:0] upper_arm;
    logic signed [DRIVE_W-1:0] linear;
  } res_t;

  typedef struct packed {
    logic signed [GOAL_W-1:0] lin;
    logic signed [GOAL_W-1:0] up;
    logic signed [GOAL_W-1:0] fore;
    logic signed [GOAL_W-1:0] tilt;
  } goal_t;

  function automatic goal_t mk_goal(input int l, input int u, input int f, input int t);
    goal_t g;
    g.lin  = GOAL_W'(l);
    g.up   = GOAL_W'(u);
    g.fore = GOAL_W'(f);
    g.tilt = GOAL_W'(t);
    return g;
  endfunction

  // Goal positions per stage; stages past the last entry hold zero goals.
  function automatic goal_t goal_rom(input logic [STAGE_W-1:0] s);
    goal_t g;
    case (s)
      4'd0:    g = mk_goal(0,      0,    480000, 0);
      4'd1:    g = mk_goal(0,      0,    240000, 0);
      4'd2:    g = mk_goal(0,      0,    240000, 100000);
      4'd3:    g = mk_goal(0,      0,    0,      100000);
      4'd4:    g = mk_goal(605000, 8100, 0,      100000);
      4'd5:    g = mk_goal(325000, 8100, 0,      100000);
      4'd6:    g = mk_goal(315000, 6450, 200000, 100000);
      4'd7:    g = mk_goal(215000, 4900, 340000, 102000);
      4'd8:    g = mk_goal(65000,  2900, 380000, 102000);
      4'd9:    g = mk_goal(30000,  500,  550000, 102000);
      4'd10:   g = mk_goal(0,      0,    636000, 102000);
      4'd11:   g = mk_goal(0,      0,    240000, 102000);
      4'd12:   g = mk_goal(0,      0,    480000, 0);
      default: g = mk_goal(0,      0,    0,      0);
    endcase
    return g;
  endfunction

  function automatic logic [COEF_W-1:0] coef_of(input logic [X_W-1:0] k);
    return COEF_W'({{(COEF_W-X_W){1'b0}}, k} * {{(COEF_W-RECIP_W){1'b0}}, RECIP50});
  endfunction

  function automatic logic [COEF_W-1:0] axis_coef(input axis_e ax, input logic half);
    logic [X_W-1:0] k;
    case (ax)
      AX_LINEAR:    k = half ? K_LIN_HALF : K_LIN_FULL;
      AX_UPPER_ARM: k = half ? K_UP_HALF : K_UP_FULL;
      AX_FOREARM:   k = half ? K_FORE_HALF : K_FORE_FULL;
      AX_TILT:      k = K_TILT;
      default:      k = K_TILT;
    endcase
    return coef_of(k);
  endfunction

  function automatic logic [X_W-1:0] axis_thr(input axis_e ax);
    logic [X_W-1:0] t;
    case (ax)
      AX_LINEAR:    t = THR_LIN;
      AX_UPPER_ARM: t = THR_UP;
      AX_FOREARM:   t = THR_FORE;
      AX_TILT:      t = THR_TILT;
      default:      t = THR_TILT;
    endcase
    return t;
  endfunction

  // Linear and tilt drive toward goal minus position, the arm joints the other way.
  function automatic logic axis_inv(input axis_e ax);
    return (ax == AX_LINEAR) || (ax == AX_TILT);
  endfunction

endpackage

@@ sv/waypoint_axis_sequencer.sv @@
// Throughput: one transaction per cycle unless m_axis_tready stalls the output; an input
// register and a result register each hold one item, and the single combinational step
// between them sets the clock period.
// Reset (rst_ni low, asynchronous): run off, stage 0, drawer latch clear, both
// registers empty, configuration registers at their documented defaults.
// Depends on wps_pkg, wps_step and wps_drive.
module waypoint_axis_sequencer #(
  parameter int unsigned POS_WIDTH = 21,
  localparam int unsigned IN_W = ((4 * POS_WIDTH + 4 + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: pos_linear, pos_upper_arm, pos_forearm, pos_tilt (POS_WIDTH each),
  //        btn_enable, btn_confirm, btn_run_a, btn_run_b, zero padding.
  input  logic [IN_W-1:0]                     s_axis_tdata,
  // tuser: func (0 position sample, 1 button event).
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: drive_linear, drive_upper_arm, drive_forearm, drive_tilt (16 each),
  //        oblique_drawer_on, flat_drawer_on, belt_on, current_stage (4), one zero bit.
  output logic [wps_pkg::OUT_W-1:0]           m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [wps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wps_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import wps_pkg::*;

  // Input register. It holds one accepted transaction until the result register
  // can take whatever that transaction produces.
  logic                        in_valid_q;
  logic                        in_func_q;
  logic signed [POS_WIDTH-1:0] pos_lin_q, pos_up_q, pos_fore_q, pos_tilt_q;
  btn_t                        btn_q;

  // Result register, the sequencer state and the configuration registers.
  logic   out_valid_q;
  res_t   out_res_q;
  state_t state_q, state_d;
  cfg_t   cfg_q;

  res_t   res;
  logic   res_valid;
  logic   advance;
  logic   take;
  logic   proc;

  // The held item moves on whenever the result register is empty or is being
  // drained this cycle. Items that produce no result (button events, samples
  // while the run is off) still pass through so that the state updates in order.
  assign advance = !out_valid_q || m_axis_tready;
  assign proc    = in_valid_q && advance;

  // A new transaction is taken whenever the input register is free or frees up
  // in this cycle, so back-to-back items stream at one per clock unless m_axis stalls.
  assign s_axis_tready = !in_valid_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  wps_step #(.POS_WIDTH(POS_WIDTH)) u_step (
    .func_i          (in_func_q),
    .pos_linear_i    (pos_lin_q),
    .pos_upper_arm_i (pos_up_q),
    .pos_forearm_i   (pos_fore_q),
    .pos_tilt_i      (pos_tilt_q),
    .btn_i           (btn_q),
    .cfg_i           (cfg_q),
    .state_i         (state_q),
    .state_o         (state_d),
    .res_o           (res),
    .res_valid_o     (res_valid)
  );

  // Control state: valid flags and the run state, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: MODE_OFF, stage: '0, latch: 1'b0};
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= proc && res_valid;
      end
      if (proc) begin
        state_q <= state_d;
      end
    end
  end

  // Config registers; writes must come only while idle, which the block does not enforce;
  // an index past the last register is ignored, and a stage start keeps its low bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tol_linear    <= RST_TOL_LINEAR;
      cfg_q.tol_upper_arm <= RST_TOL_UPPER_ARM;
      cfg_q.tol_forearm   <= RST_TOL_FOREARM;
      cfg_q.tol_tilt      <= RST_TOL_TILT;
      cfg_q.start_a       <= RST_START_A;
      cfg_q.start_b       <= RST_START_B;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOL_LINEAR:    cfg_q.tol_linear    <= cfg_wdata_i;
        CFG_TOL_UPPER_ARM: cfg_q.tol_upper_arm <= cfg_wdata_i;
        CFG_TOL_FOREARM:   cfg_q.tol_forearm   <= cfg_wdata_i;
        CFG_TOL_TILT:      cfg_q.tol_tilt      <= cfg_wdata_i;
        CFG_START_A:       cfg_q.start_a       <= cfg_wdata_i[STAGE_W-1:0];
        CFG_START_B:       cfg_q.start_b       <= cfg_wdata_i[STAGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers need no reset; their valid flags guard them.
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_func_q  <= s_axis_tuser;
      pos_lin_q  <= s_axis_tdata[0 * POS_WIDTH +: POS_WIDTH];
      pos_up_q   <= s_axis_tdata[1 * POS_WIDTH +: POS_WIDTH];
      pos_fore_q <= s_axis_tdata[2 * POS_WIDTH +: POS_WIDTH];
      pos_tilt_q <= s_axis_tdata[3 * POS_WIDTH +: POS_WIDTH];
      btn_q      <= btn_t'(s_axis_tdata[4 * POS_WIDTH +: 4]);
    end
    if (proc && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q};

endmodule

@@ sv/wps_drive.sv @@
// Proportional drive for one axis: clip, optional halving, Q8.8 rounding, zero band.
// Depends on wps_pkg for gains, thresholds and the reciprocal divide constants.
module wps_drive #(
  parameter int unsigned    ERR_W = 22,
  parameter wps_pkg::axis_e AXIS  = wps_pkg::AX_LINEAR
) (
  input  logic signed [ERR_W-1:0]            diff_i,
  input  logic                               half_i,
  input  logic [wps_pkg::TOL_W-1:0]          band_i,
  output logic signed [wps_pkg::DRIVE_W-1:0] drive_o
);
  import wps_pkg::*;

  localparam logic [X_W-1:0]    THR    = axis_thr(AXIS);
  localparam logic [COEF_W-1:0] C_FULL = axis_coef(AXIS, 1'b0);
  localparam logic [COEF_W-1:0] C_HALF = axis_coef(AXIS, 1'b1);
  localparam logic              INV    = axis_inv(AXIS);

  logic [ERR_W-1:0]  mag;
  logic              sat;
  logic [X_W-1:0]    x;
  logic [COEF_W-1:0] coef;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q;
  logic [Q_W-1:0]    q_band;
  logic              neg;

  always_comb begin
    mag  = diff_i[ERR_W-1] ? ERR_W'(-diff_i) : ERR_W'(diff_i);
    sat  = mag >= {{(ERR_W-X_W){1'b0}}, THR};
    x    = mag[X_W-1:0];
    coef = half_i ? C_HALF : C_FULL;
    // Rounded divide by 50 through the reciprocal; exact below the clip point.
    prod = PROD_W'(x) * PROD_W'(coef) + PROD_W'(ROUND_OFS);
    if (sat) begin
      q = half_i ? DRIVE_HALF : DRIVE_FULL;
    end else begin
      q = prod[DIV_SHIFT +: Q_W];
    end
    q_band  = (mag < {{(ERR_W-TOL_W){1'b0}}, band_i}) ? '0 : q;
    neg     = diff_i[ERR_W-1] ^ INV;
    drive_o = neg ? -$signed(DRIVE_W'(q_band)) : $signed(DRIVE_W'(q_band));
  end

endmodule

@@ sv/wps_step.sv @@
// Next-state and result logic for one transaction: button decode, arrival test, drives.
// Depends on wps_pkg and instantiates one wps_drive per axis.
module wps_step #(
  parameter int unsigned POS_WIDTH = 21
) (
  input  logic                        func_i,
  input  logic signed [POS_WIDTH-1:0] pos_linear_i,
  input  logic signed [POS_WIDTH-1:0] pos_upper_arm_i,
  input  logic signed [POS_WIDTH-1:0] pos_forearm_i,
  input  logic signed [POS_WIDTH-1:0] pos_tilt_i,
  input  wps_pkg::btn_t               btn_i,
  input  wps_pkg::cfg_t               cfg_i,
  input  wps_pkg::state_t             state_i,
  output wps_pkg::state_t             state_o,
  output wps_pkg::res_t               res_o,
  output logic                        res_valid_o
);
  import wps_pkg::*;

  localparam int unsigned ERR_W = ((POS_WIDTH > GOAL_W) ? POS_WIDTH : GOAL_W) + 1;

  goal_t              g_cur;
  goal_t              g_nxt;
  logic signed [ERR_W-1:0] pl, pu, pf, pt;
  logic signed [ERR_W-1:0] dc_l, dc_u, dc_f, dc_t;
  logic signed [ERR_W-1:0] dn_l, dn_u, dn_f, dn_t;
  logic signed [ERR_W-1:0] d_l, d_u, d_f, d_t;
  logic [ERR_W-1:0]   m_l, m_u, m_f, m_t;
  logic               arrive;
  logic               stop_pre;
  logic               step_up;
  logic [STAGE_W-1:0] s_new;
  logic               stop;
  logic               half_lu;
  logic               half_fore;
  logic               en;
  logic signed [DRIVE_W-1:0] dr_l, dr_u, dr_f, dr_t;

  function automatic logic [ERR_W-1:0] abs_e(input logic signed [ERR_W-1:0] v);
    return v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
  endfunction

  always_comb begin
    pl = ERR_W'(pos_linear_i);
    pu = ERR_W'(pos_upper_arm_i);
    pf = ERR_W'(pos_forearm_i);
    pt = ERR_W'(pos_tilt_i);

    g_cur = goal_rom(state_i.stage);
    g_nxt = goal_rom(STAGE_W'(state_i.stage + 4'd1));

    // Position minus goal for the present stage and the one after it.
    dc_l = pl - ERR_W'(g_cur.lin);
    dc_u = pu - ERR_W'(g_cur.up);
    dc_f = pf - ERR_W'(g_cur.fore);
    dc_t = pt - ERR_W'(g_cur.tilt);
    dn_l = pl - ERR_W'(g_nxt.lin);
    dn_u = pu - ERR_W'(g_nxt.up);
    dn_f = pf - ERR_W'(g_nxt.fore);
    dn_t = pt - ERR_W'(g_nxt.tilt);

    m_l = abs_e(dc_l);
    m_u = abs_e(dc_u);
    m_f = abs_e(dc_f);
    m_t = abs_e(dc_t);
    arrive = (m_l < ERR_W'(cfg_i.tol_linear)) && (m_u < ERR_W'(cfg_i.tol_upper_arm)) &&
             (m_f < ERR_W'(cfg_i.tol_forearm)) && (m_t < ERR_W'(cfg_i.tol_tilt));

    stop_pre = (state_i.stage >= NUM_STAGES) ||
               ((state_i.mode == MODE_A) && (state_i.stage == SPLIT_STAGE));
    step_up  = !stop_pre && arrive;
    s_new    = step_up ? STAGE_W'(state_i.stage + 4'd1) : state_i.stage;
    stop     = stop_pre || (s_new >= NUM_STAGES);

    d_l = step_up ? dn_l : dc_l;
    d_u = step_up ? dn_u : dc_u;
    d_f = step_up ? dn_f : dc_f;
    d_t = step_up ? dn_t : dc_t;

    half_lu   = s_new == HALF_STAGE_LU;
    half_fore = s_new == HALF_STAGE_FORE;
  end

  wps_drive #(.ERR_W(ERR_W), .AXIS(AX_LINEAR)) u_drv_lin (
    .diff_i (d_l), .half_i (half_lu), .band_i ('0), .drive_o (dr_l)
  );
  wps_drive #(.ERR_W(ERR_W), .AXIS(AX_UPPER_ARM)) u_drv_up (
    .diff_i (d_u), .half_i (half_lu), .band_i ('0), .drive_o (dr_u)
  );
  wps_drive #(.ERR_W(ERR_W), .AXIS(AX_FOREARM)) u_drv_fore (
    .diff_i (d_f), .half_i (half_fore), .band_i ('0), .drive_o (dr_f)
  );
  wps_drive #(.ERR_W(ERR_W), .AXIS(AX_TILT)) u_drv_tilt (
    .diff_i (d_t), .half_i (1'b0), .band_i (cfg_i.tol_tilt), .drive_o (dr_t)
  );

  always_comb begin
    state_o     = state_i;
    res_o       = '0;
    res_valid_o = 1'b0;
    en          = btn_i.enable && btn_i.confirm;
    if (func_i) begin
      if (en && btn_i.run_a) begin
        state_o.mode  = MODE_A;
        state_o.stage = cfg_i.start_a;
      end else if (en && btn_i.run_b) begin
        state_o.mode  = MODE_B;
        state_o.stage = cfg_i.start_b;
      end else begin
        state_o.mode  = MODE_OFF;
        state_o.stage = '0;
      end
    end else if (state_i.mode != MODE_OFF) begin
      res_valid_o   = 1'b1;
      state_o.stage = s_new;
      res_o.stage   = s_new;
      if (stop) begin
        state_o.latch = 1'b0;
      end else begin
        state_o.latch     = state_i.latch || (s_new >= FLAT_STAGE);
        res_o.linear      = dr_l;
        res_o.upper_arm   = dr_u;
        res_o.forearm     = dr_f;
        res_o.tilt        = dr_t;
        res_o.oblique     = state_i.latch || (s_new >= FLAT_STAGE);
        res_o.flat        = s_new >= FLAT_STAGE;
        res_o.belt        = (s_new >= BELT_FIRST) && (s_new <= BELT_LAST);
      end
    end
  end

endmodule

@@ sv/wps_checker.sv @@
// Port-level checker for the waypoint axis sequencer, bound to the top level.
// Depends on wps_pkg and waypoint_axis_sequencer_macros.svh.
`include "waypoint_axis_sequencer_macros.svh"

module wps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready,
  input logic [wps_pkg::OUT_W-1:0]   m_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready
);
  import wps_pkg::*;

  `WPS_ASSERT_NEXT(a_out_valid_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result transaction dropped while stalled")

  `WPS_ASSERT_NEXT(a_out_data_held, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result data changed while stalled")

  // A free or draining result register always opens the input side.
  `WPS_ASSERT_IMPLIES(a_ready_when_drained, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled although the result register can advance")

  // Past the last stage the result carries no drive and no flag.
  `WPS_ASSERT_IMPLIES(a_end_stage_zero, m_axis_tvalid && (m_axis_tdata[OUT_STAGE_LSB +: STAGE_W] >= NUM_STAGES), m_axis_tdata[OUT_STAGE_LSB-1:0] == '0, "drive or flag set past the last stage")

  `WPS_ASSERT_IMPLIES(a_flat_needs_stage, m_axis_tvalid && m_axis_tdata[OUT_FLAT_BIT], m_axis_tdata[OUT_STAGE_LSB +: STAGE_W] >= FLAT_STAGE, "flat drawer on before its stage")

endmodule

bind waypoint_axis_sequencer wps_checker u_wps_checker (.*);
